// File: sv/mat_pkg.sv
// package for the microsecond alarm timer
// holds widths, function codes, conversion constants and the stage struct
// no dependencies
package mat_pkg;

	localparam int COUNTER_BITS = 52;

	localparam int FUNC_W    = 2;
	localparam int SEC_IN_W  = 34;
	localparam int NS_W      = 30;
	localparam int SEC_OUT_W = 33;
	localparam int MARGIN_W  = 10;
	localparam int USEC_W    = 20;
	localparam int PROD_W    = SEC_IN_W + USEC_W;
	localparam int WIDE_W    = 65;
	localparam int RND_W     = NS_W + 1;
	localparam int DIV_IN_W  = RND_W - 3;
	localparam int DIV_MUL_W = 29;
	localparam int DIV_P_W   = DIV_IN_W + DIV_MUL_W;
	localparam int DIV_SHIFT = 35;
	localparam int US_W      = 21;

	localparam logic [MARGIN_W-1:0]     MARGIN_RESET = 10'd10;
	localparam logic [COUNTER_BITS-1:0] COUNT_MAX    = '1;
	localparam logic [COUNTER_BITS-1:0] LIMIT_SECS   = COUNT_MAX / 1000000;
	localparam logic [WIDE_W-1:0]       LIMIT_WIDE   = WIDE_W'(LIMIT_SECS);
	localparam logic [WIDE_W-1:0]       MAX_WIDE     = WIDE_W'(COUNT_MAX);

	localparam logic [USEC_W-1:0]    USEC_IN_SEC  = 20'd1000000;
	localparam logic [USEC_W-1:0]    USEC_LAST    = 20'd999999;
	localparam logic [NS_W-1:0]      NS_PER_US    = 30'd1000;
	localparam logic [RND_W-1:0]     ROUND_ADD    = 31'd999;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL      = 29'd274877907;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_SET    = 2'd1,
		FUNC_CANCEL = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	typedef struct packed {
		func_t             func;
		logic              clamp;
		logic [PROD_W-1:0] prod;
		logic [US_W-1:0]   us;
	} mat_s2_t;

endpackage

// File: sv/mat_cmd_if.sv
// input channel of the microsecond alarm timer: valid, ready and the item fields
// depends on mat_pkg
interface mat_cmd_if;
	import mat_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SEC_IN_W-1:0] seconds;
	logic [NS_W-1:0]     nanoseconds;

	modport source (output valid, output func, output seconds, output nanoseconds,
		input ready);
	modport sink (input valid, input func, input seconds, input nanoseconds,
		output ready);
endinterface

// File: sv/mat_rsp_if.sv
// result channel of the microsecond alarm timer: valid, ready and the result fields
// depends on mat_pkg
interface mat_rsp_if;
	import mat_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [SEC_OUT_W-1:0] now_seconds;
	logic [NS_W-1:0]      now_nanoseconds;
	logic                 alarm_fired;
	logic                 alarm_armed;

	modport source (output valid, output now_seconds, output now_nanoseconds,
		output alarm_fired, output alarm_armed, input ready);
	modport sink (input valid, input now_seconds, input now_nanoseconds,
		input alarm_fired, input alarm_armed, output ready);
endinterface

// File: sv/microsecond_alarm_timer_unit.sv
// Microsecond alarm timer with compare-match alarm. Items enter on cmd and each
// gives exactly one result on rsp, in order. One item is taken every clock cycle
// when rsp is not stalled; each item passes the input register, the conversion
// register and the result register, in that order, before its result shows on rsp.
// Time reads come from a seconds/microseconds copy kept in step with the counter,
// so no divider sits in the path. The user writes alarm_margin through cfg_wen/cfg_wdata
// only while no item is in flight (not enforced by the block); it resets to 10.
module microsecond_alarm_timer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	mat_cmd_if.sink                      cmd,
	mat_rsp_if.source                    rsp,
	input  logic                         cfg_wen,
	input  logic [mat_pkg::MARGIN_W-1:0] cfg_wdata
);
	import mat_pkg::*;

	logic [MARGIN_W-1:0] margin_q;
	logic                s2_valid;
	logic                s2_take;
	mat_s2_t             s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_wen) begin
			margin_q <= cfg_wdata;
		end
	end

	mat_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s2_take  (s2_take),
		.s2_valid (s2_valid),
		.s2       (s2)
	);

	mat_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.margin   (margin_q),
		.s2_valid (s2_valid),
		.s2       (s2),
		.s2_take  (s2_take),
		.rsp      (rsp)
	);
endmodule

// File: sv/mat_prep.sv
// input register and alarm time conversion stage
// seconds times one million and rounded-up microseconds of the nanoseconds; depends on mat_pkg
module mat_prep (
	input  logic              clk,
	input  logic              arst_n,
	mat_cmd_if.sink           cmd,
	input  logic              s2_take,
	output logic              s2_valid,
	output mat_pkg::mat_s2_t  s2
);
	import mat_pkg::*;

	logic                s1_valid_q;
	func_t               func_s1;
	logic [SEC_IN_W-1:0] secs_s1;
	logic [NS_W-1:0]     nanos_s1;
	logic                s2_valid_q;
	mat_s2_t             s2_q;
	logic                s1_free;
	logic                s2_free;
	logic [RND_W-1:0]    ns_rnd;
	logic [DIV_P_W-1:0]  div_p;
	mat_s2_t             s2_nx;

	assign s2_free   = !s2_valid_q || s2_take;
	assign s1_free   = !s1_valid_q || s2_free;
	assign cmd.ready = s1_free;
	assign s2_valid  = s2_valid_q;
	assign s2        = s2_q;

	always_comb begin
		ns_rnd      = RND_W'(nanos_s1) + ROUND_ADD;
		div_p       = DIV_P_W'(ns_rnd[RND_W-1:3]) * DIV_P_W'(DIV_MUL);
		s2_nx.func  = func_s1;
		s2_nx.clamp = WIDE_W'(secs_s1) >= LIMIT_WIDE;
		s2_nx.prod  = PROD_W'(secs_s1) * PROD_W'(USEC_IN_SEC);
		s2_nx.us    = div_p[DIV_SHIFT+US_W-1:DIV_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= cmd.valid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && s1_free) begin
			func_s1  <= func_t'(cmd.func);
			secs_s1  <= cmd.seconds;
			nanos_s1 <= cmd.nanoseconds;
		end
		if (s1_valid_q && s2_free) begin
			s2_q <= s2_nx;
		end
	end
endmodule

// File: sv/mat_core.sv
// timer state, alarm compare and result register
// keeps the counter alongside a seconds/microseconds copy for time reads; depends on mat_pkg
module mat_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mat_pkg::MARGIN_W-1:0]  margin,
	input  logic                          s2_valid,
	input  mat_pkg::mat_s2_t              s2,
	output logic                          s2_take,
	mat_rsp_if.source                     rsp
);
	import mat_pkg::*;

	logic [COUNTER_BITS-1:0] cnt_q;
	logic [COUNTER_BITS-1:0] cmp_q;
	logic                    armed_q;
	logic [SEC_OUT_W-1:0]    sec_q;
	logic [USEC_W-1:0]       usec_q;
	logic                    out_valid_q;
	logic [SEC_OUT_W-1:0]    now_s_q;
	logic [NS_W-1:0]         now_ns_q;
	logic                    fired_q;
	logic                    armed_out_q;

	logic                    commit;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic                    cnt_wrap;
	logic                    fire;
	logic [WIDE_W-1:0]       sum;
	logic [COUNTER_BITS-1:0] tgt_c;
	logic [COUNTER_BITS-1:0] floor_w;
	logic [COUNTER_BITS-1:0] target;
	logic                    armed_nx;
	logic                    report;

	assign s2_take = !out_valid_q || rsp.ready;
	assign commit  = s2_valid && s2_take;

	always_comb begin
		cnt_inc  = cnt_q + COUNTER_BITS'(1);
		cnt_wrap = cnt_q == COUNT_MAX;
		fire     = armed_q && (cnt_inc >= cmp_q);
		sum      = WIDE_W'(s2.prod) + WIDE_W'(s2.us);
		tgt_c    = (s2.clamp || sum > MAX_WIDE) ? COUNT_MAX : sum[COUNTER_BITS-1:0];
		floor_w  = cnt_q + COUNTER_BITS'(margin);
		target   = (tgt_c <= floor_w) ? floor_w : tgt_c;
		report   = 1'b0;
		case (s2.func)
			FUNC_TICK: begin
				armed_nx = armed_q && !fire;
			end
			FUNC_SET: begin
				armed_nx = 1'b1;
			end
			FUNC_CANCEL: begin
				armed_nx = 1'b0;
				report   = 1'b1;
			end
			default: begin
				armed_nx = armed_q;
				report   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cmp_q       <= '0;
			armed_q     <= 1'b0;
			sec_q       <= '0;
			usec_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_take) begin
				out_valid_q <= s2_valid;
			end
			if (commit) begin
				armed_q <= armed_nx;
				if (s2.func == FUNC_SET) begin
					cmp_q <= target;
				end
				if (s2.func == FUNC_TICK) begin
					cnt_q <= cnt_inc;
					if (cnt_wrap) begin
						sec_q  <= '0;
						usec_q <= '0;
					end else if (usec_q == USEC_LAST) begin
						sec_q  <= sec_q + SEC_OUT_W'(1);
						usec_q <= '0;
					end else begin
						usec_q <= usec_q + USEC_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			now_s_q     <= report ? sec_q : '0;
			now_ns_q    <= report ? NS_W'(usec_q) * NS_PER_US : '0;
			fired_q     <= (s2.func == FUNC_TICK) && fire;
			armed_out_q <= armed_nx;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.now_seconds     = now_s_q;
	assign rsp.now_nanoseconds = now_ns_q;
	assign rsp.alarm_fired     = fired_q;
	assign rsp.alarm_armed     = armed_out_q;

`ifndef SYNTH
	a_usec_range: assert property (@(posedge clk) disable iff (!arst_n)
		usec_q < USEC_IN_SEC)
		else $error("microsecond part out of range");

	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fired_q |-> !armed_out_q)
		else $error("fired result still armed");

	a_set_arms: assert property (@(posedge clk) disable iff (!arst_n)
		commit && s2.func == FUNC_SET |=> armed_q && cmp_q >= $past(floor_w))
		else $error("set alarm left target below floor or not armed");

	a_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		commit && s2.func == FUNC_CANCEL |=> !armed_q)
		else $error("cancel did not disarm");
`endif
endmodule
